// File: src/text_marquee_window_unit_assert.svh
// Assertion macros for the text marquee window checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_MARQUEE_WINDOW_UNIT_ASSERT_SVH
`define TEXT_MARQUEE_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TMW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmw assertion failed");

// Next-cycle implication.
`define TMW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmw assertion failed");

`endif

// File: src/tmw_pkg.sv
// Package for the text marquee window unit: field widths, codes and the
// microcode ROM of the sequencer. No dependencies.
package tmw_pkg;

  localparam int unsigned TEXT_MAX_DEF = 64;
  localparam int unsigned COLS_MAX_DEF = 39;

  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 6;
  localparam int ROWS_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [COL_W-1:0]  COLS_RESET = 6'd20;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ROW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  // Commands and directions
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam logic [DIR_W-1:0] DIR_FWD = 2'b01;

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_FETCH      = 4'd0;
  localparam logic [UPC_W-1:0] U_DISPATCH   = 4'd1;
  localparam logic [UPC_W-1:0] U_LD_READ    = 4'd2;
  localparam logic [UPC_W-1:0] U_LD_WRITE   = 4'd3;
  localparam logic [UPC_W-1:0] U_LD_COMMIT  = 4'd4;
  localparam logic [UPC_W-1:0] U_ST_ROW     = 4'd5;
  localparam logic [UPC_W-1:0] U_ST_EMPTY   = 4'd6;
  localparam logic [UPC_W-1:0] U_ST_DIR     = 4'd7;
  localparam logic [UPC_W-1:0] U_ST_DIV     = 4'd8;
  localparam logic [UPC_W-1:0] U_ST_WIN     = 4'd9;
  localparam logic [UPC_W-1:0] U_ST_ADDR    = 4'd10;
  localparam logic [UPC_W-1:0] U_ST_OUT     = 4'd11;
  localparam logic [UPC_W-1:0] U_ST_DONE    = 4'd12;
  localparam logic [UPC_W-1:0] U_EMIT_BAD   = 4'd13;
  localparam logic [UPC_W-1:0] U_EMIT_EMPTY = 4'd14;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_FETCH      = 4'd1;
  localparam logic [OP_W-1:0] OP_LD_READ    = 4'd2;
  localparam logic [OP_W-1:0] OP_LD_WRITE   = 4'd3;
  localparam logic [OP_W-1:0] OP_COMMIT     = 4'd4;
  localparam logic [OP_W-1:0] OP_ROW        = 4'd5;
  localparam logic [OP_W-1:0] OP_DIR        = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV        = 4'd7;
  localparam logic [OP_W-1:0] OP_WIN_INIT   = 4'd8;
  localparam logic [OP_W-1:0] OP_ADDR       = 4'd9;
  localparam logic [OP_W-1:0] OP_OUT        = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT_BAD   = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT_EMPTY = 4'd12;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] C_NO_IN     = 4'd2;
  localparam logic [COND_W-1:0] C_IS_STEP   = 4'd3;
  localparam logic [COND_W-1:0] C_BAD_ROW   = 4'd4;
  localparam logic [COND_W-1:0] C_EMPTY     = 4'd5;
  localparam logic [COND_W-1:0] C_NOT_FWD   = 4'd6;
  localparam logic [COND_W-1:0] C_DIV_MORE  = 4'd7;
  localparam logic [COND_W-1:0] C_NO_COLS   = 4'd8;
  localparam logic [COND_W-1:0] C_MORE_COLS = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
    logic              wait_out;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: U_FETCH, wait_out: 1'b0};
    unique case (addr)
      U_FETCH: begin
        w.op = OP_FETCH; w.cond = C_NO_IN; w.target = U_FETCH;
      end
      U_DISPATCH: begin
        w.cond = C_IS_STEP; w.target = U_ST_ROW;
      end
      U_LD_READ:   w.op = OP_LD_READ;
      U_LD_WRITE:  w.op = OP_LD_WRITE;
      U_LD_COMMIT: begin
        w.op = OP_COMMIT; w.cond = C_ALWAYS; w.target = U_FETCH;
      end
      U_ST_ROW: begin
        w.op = OP_ROW; w.cond = C_BAD_ROW; w.target = U_EMIT_BAD;
      end
      U_ST_EMPTY: begin
        w.cond = C_EMPTY; w.target = U_EMIT_EMPTY;
      end
      U_ST_DIR: begin
        w.op = OP_DIR; w.cond = C_NOT_FWD; w.target = U_ST_WIN;
      end
      U_ST_DIV: begin
        w.op = OP_DIV; w.cond = C_DIV_MORE; w.target = U_ST_DIV;
      end
      U_ST_WIN: begin
        w.op = OP_WIN_INIT; w.cond = C_NO_COLS; w.target = U_FETCH;
      end
      U_ST_ADDR: w.op = OP_ADDR;
      U_ST_OUT: begin
        w.op = OP_OUT; w.cond = C_MORE_COLS; w.target = U_ST_ADDR; w.wait_out = 1'b1;
      end
      U_ST_DONE: begin
        w.cond = C_ALWAYS; w.target = U_FETCH;
      end
      U_EMIT_BAD: begin
        w.op = OP_EMIT_BAD; w.cond = C_ALWAYS; w.target = U_FETCH; w.wait_out = 1'b1;
      end
      U_EMIT_EMPTY: begin
        w.op = OP_EMIT_EMPTY; w.cond = C_ALWAYS; w.target = U_FETCH; w.wait_out = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = U_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/tmw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module tmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/text_marquee_window_unit.sv
// Top level of the text marquee window unit: microcoded sequencer and datapath.
// Depends on tmw_pkg and tmw_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid_i/in_ready_o | command, char_code, final_char, direction, row
//   out     | output    | out_valid_o/out_ready_i | out_row, out_column, out_char, status, last
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time; an in-channel item is taken only when the sequencer sits at its fetch step.
// Load: read, write, commit. Status result from the row check or the empty check.
// Step: row, empty and direction checks, plus the remainder loop on a forward move, then
// window init and an address and emit step per column, one text store read per column.
// Output stalls hold the sequencer at its emit step. No clearing pass after reset.
module text_marquee_window_unit import tmw_pkg::*; #(
  parameter int unsigned TEXT_MAX = TEXT_MAX_DEF,
  parameter int unsigned COLS_MAX = COLS_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic                  final_char_i,
  input  logic signed [DIR_W-1:0] direction_i,
  input  logic [ROW_W-1:0]      row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_column_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LenW = $clog2(TEXT_MAX);
  localparam int ModW = $clog2(TEXT_MAX + 63);
  localparam int BitW = $clog2(ModW);
  localparam logic [LenW-1:0]  LastPtr  = LenW'(TEXT_MAX - 1);
  localparam logic [COL_W-1:0] ColsMaxC = COL_W'(COLS_MAX);
  localparam logic [BitW-1:0]  BitTop   = BitW'(ModW - 1);

  // Sequencer
  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           uw;
  logic             stall, op_en, cond_hit;

  // Latched item
  logic              cmd_q;
  logic [CHAR_W-1:0] ch_q;
  logic              fin_q;
  logic [DIR_W-1:0]  dir_q;
  logic [ROW_W-1:0]  row_q;
  logic              in_acc;

  // Configuration
  logic [COL_W-1:0]  cols_cfg_q;
  logic [ROWS_W-1:0] rows_cfg_q;

  // Architectural state
  logic [LenW-1:0]  len_q, len_d;
  logic [ModW-1:0]  off_q, off_d;
  logic [ROW_W-1:0] saved_row_q, saved_row_d;
  logic [LenW-1:0]  lp_q, lp_d;
  logic             differs_q, differs_d;

  // Working registers
  logic [ModW-1:0]  div_x_q, div_x_d;
  logic [ModW-1:0]  rem_q, rem_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             sel_text_q, sel_text_d;

  // Output register
  logic                out_valid_q, out_valid_d, out_load;
  logic [ROW_W-1:0]    o_row_q, o_row_d;
  logic [COL_W-1:0]    o_col_q, o_col_d;
  logic [CHAR_W-1:0]   o_char_q, o_char_d;
  logic [STATUS_W-1:0] o_status_q, o_status_d;
  logic                o_last_q, o_last_d;

  // Datapath terms
  logic [COL_W-1:0]  cols_eff, col_next;
  logic [ModW-1:0]   modulus, span;
  logic [ModW:0]     idx, wrap, rem_shift, rem_sub;
  logic [ModW-1:0]   rem_next;
  logic              bad_row, text_empty, ld_take, last_col, in_text, in_wrap;
  logic [LenW-1:0]   ram_raddr;
  logic              ram_we;
  logic [CHAR_W-1:0] ram_rdata;

  assign uw    = ucode_rom(upc_q);
  assign stall = uw.wait_out && out_valid_q && !out_ready_i;
  assign op_en = !stall;

  assign in_ready_o  = (upc_q == U_FETCH);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign cols_eff   = (cols_cfg_q > ColsMaxC) ? ColsMaxC : cols_cfg_q;
  assign col_next   = col_q + COL_W'(1);
  assign last_col   = (col_next == cols_eff);
  assign modulus    = ModW'(len_q) + ModW'(cols_cfg_q);
  assign span       = ModW'(len_q) + ModW'(cols_eff);
  assign idx        = {1'b0, off_q} + (ModW+1)'(col_q);
  assign wrap       = idx - {1'b0, span};
  assign in_text    = (idx < (ModW+1)'(len_q));
  assign in_wrap    = (idx >= {1'b0, span}) && (wrap < (ModW+1)'(len_q));
  assign bad_row    = ({1'b0, row_q} >= rows_cfg_q);
  assign text_empty = (len_q == '0);
  assign ld_take    = (ch_q != '0) && (lp_q < LastPtr);

  // One bit of restoring remainder per cycle
  assign rem_shift = {rem_q, div_x_q[bit_q]};
  assign rem_sub   = rem_shift - {1'b0, modulus};
  assign rem_next  = (rem_shift >= {1'b0, modulus}) ? rem_sub[ModW-1:0] : rem_shift[ModW-1:0];

  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_IN:     cond_hit = !in_valid_i;
      C_IS_STEP:   cond_hit = (cmd_q == CMD_STEP);
      C_BAD_ROW:   cond_hit = bad_row;
      C_EMPTY:     cond_hit = text_empty;
      C_NOT_FWD:   cond_hit = (dir_q != DIR_FWD);
      C_DIV_MORE:  cond_hit = (bit_q != '0);
      C_NO_COLS:   cond_hit = (cols_eff == '0);
      C_MORE_COLS: cond_hit = !last_col;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      upc_d = upc_q;
    end else if (cond_hit) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  // Hold the window address through the emit step so a stall keeps the read data
  assign ram_raddr = ((uw.op == OP_ADDR) || (uw.op == OP_OUT)) ?
                     (in_text ? idx[LenW-1:0] : wrap[LenW-1:0]) : lp_q;
  assign ram_we    = op_en && (uw.op == OP_LD_WRITE) && ld_take;

  always_comb begin
    len_d       = len_q;
    off_d       = off_q;
    saved_row_d = saved_row_q;
    lp_d        = lp_q;
    differs_d   = differs_q;
    div_x_d     = div_x_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    col_d       = col_q;
    sel_text_d  = sel_text_q;
    out_load    = 1'b0;
    o_row_d     = o_row_q;
    o_col_d     = o_col_q;
    o_char_d    = o_char_q;
    o_status_d  = o_status_q;
    o_last_d    = o_last_q;
    if (op_en) begin
      unique case (uw.op) inside
        OP_LD_READ: begin
          // overlong text: drop the character
          if ((ch_q != '0) && !ld_take) begin
            differs_d = 1'b1;
          end
        end
        OP_LD_WRITE: begin
          if (ld_take) begin
            if ((lp_q >= len_q) || (ram_rdata != ch_q)) begin
              differs_d = 1'b1;
            end
            lp_d = lp_q + LenW'(1);
          end
        end
        OP_COMMIT: begin
          if (fin_q) begin
            len_d = lp_q;
            if (differs_q || (lp_q != len_q)) begin
              off_d = '0;
            end
            lp_d      = '0;
            differs_d = 1'b0;
          end
        end
        OP_ROW: begin
          if (!bad_row && (row_q != saved_row_q)) begin
            off_d       = '0;
            saved_row_d = row_q;
          end
        end
        OP_DIR: begin
          if (dir_q == DIR_FWD) begin
            div_x_d = off_q + ModW'(1);
            rem_d   = '0;
            bit_d   = BitTop;
          end else if (dir_q[DIR_W-1]) begin
            off_d = (off_q == '0) ? (modulus - ModW'(1)) : (off_q - ModW'(1));
          end
        end
        OP_DIV: begin
          rem_d = rem_next;
          bit_d = bit_q - BitW'(1);
          if (bit_q == '0) begin
            off_d = rem_next;
          end
        end
        OP_WIN_INIT: col_d = '0;
        OP_ADDR:     sel_text_d = in_text || in_wrap;
        OP_OUT: begin
          out_load   = 1'b1;
          o_row_d    = row_q;
          o_col_d    = col_q;
          o_char_d   = sel_text_q ? ram_rdata : BLANK_CHAR;
          o_status_d = STATUS_OK;
          o_last_d   = last_col;
          col_d      = col_next;
        end
        OP_EMIT_BAD, OP_EMIT_EMPTY: begin
          out_load   = 1'b1;
          o_row_d    = row_q;
          o_col_d    = '0;
          o_char_d   = '0;
          o_status_d = (uw.op == OP_EMIT_BAD) ? STATUS_BAD_ROW : STATUS_EMPTY;
          o_last_d   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_FETCH;
      cols_cfg_q  <= COLS_RESET;
      rows_cfg_q  <= ROWS_RESET;
      len_q       <= '0;
      off_q       <= '0;
      saved_row_q <= '0;
      lp_q        <= '0;
      differs_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      len_q       <= len_d;
      off_q       <= off_d;
      saved_row_q <= saved_row_d;
      lp_q        <= lp_d;
      differs_q   <= differs_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_COLUMNS: cols_cfg_q <= cfg_data_i;
          CFG_ROWS:    rows_cfg_q <= cfg_data_i[ROWS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      ch_q  <= char_code_i;
      fin_q <= final_char_i;
      dir_q <= direction_i;
      row_q <= row_i;
    end
    div_x_q    <= div_x_d;
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    col_q      <= col_d;
    sel_text_q <= sel_text_d;
    o_row_q    <= o_row_d;
    o_col_q    <= o_col_d;
    o_char_q   <= o_char_d;
    o_status_q <= o_status_d;
    o_last_q   <= o_last_d;
  end

  tmw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(TEXT_MAX)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lp_q),
    .wdata_i(ch_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = o_row_q;
  assign out_column_o = o_col_q;
  assign out_char_o   = o_char_q;
  assign status_o     = o_status_q;
  assign last_o       = o_last_q;

endmodule

// File: src/tmw_checker.sv
// Port-level checker for the text marquee window unit, bound to the top level.
// Depends on tmw_pkg and text_marquee_window_unit_assert.svh.
`include "text_marquee_window_unit_assert.svh"

module tmw_checker import tmw_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COL_W-1:0]      out_column_o,
  input logic [CHAR_W-1:0]     out_char_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic                  last_o
);

  // A status transaction is a single, final result with column and character zero
  `TMW_ASSERT_NOW(a_status_shape, out_valid_o && (status_o != STATUS_OK), last_o && (out_column_o == '0) && (out_char_o == '0))

  // No new item is taken while a window is still being emitted
  `TMW_ASSERT_NOW(a_no_fetch_mid_window, out_valid_o && !last_o, !in_ready_o)

  // Hold a stalled result
  `TMW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_char_o) && $stable(out_column_o) && $stable(last_o))

endmodule

bind text_marquee_window_unit tmw_checker u_tmw_checker (.*);
